### sv/mpool_pkg.sv
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared types and constants for the unsigned 8-bit max pooling block.
// ----------------------------------------------------------------------------
package mpool_pkg;

    localparam int DIM_W   = 7;
    localparam int PAD_W   = 6;
    localparam int POS_W   = 6;
    localparam int CH_W    = 4;
    localparam int PIX_W   = 8;
    localparam int SPAN_W  = 15;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 7'd64;
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_KERNEL     = 7'd3;
    localparam logic [DIM_W-1:0] RST_STRIDE     = 7'd1;
    localparam logic [PAD_W-1:0] RST_PAD        = 6'd0;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [2:0]
    {
        REG_SRC_HEIGHT = 3'd0,
        REG_SRC_WIDTH  = 3'd1,
        REG_KERNEL_Y   = 3'd2,
        REG_KERNEL_X   = 3'd3,
        REG_STRIDE_Y   = 3'd4,
        REG_STRIDE_X   = 3'd5,
        REG_PAD_Y      = 3'd6,
        REG_PAD_X      = 3'd7
    } reg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SPAN,
        ST_CLAMP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [DIM_W-1:0] src_height;
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] kernel_y;
        logic [DIM_W-1:0] kernel_x;
        logic [DIM_W-1:0] stride_y;
        logic [DIM_W-1:0] stride_x;
        logic [PAD_W-1:0] pad_y;
        logic [PAD_W-1:0] pad_x;
    } cfg_t;

    typedef struct packed
    {
        logic accept;
        logic span;
        logic clamp;
        logic scan;
        logic out_load;
    } cmd_t;

    typedef struct packed
    {
        logic win_ok;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

### sv/mpool_item_if.sv
// ----------------------------------------------------------------------------
// mpool_item_if
// Request channel: load one source byte or query one pooled output.
// ----------------------------------------------------------------------------
interface mpool_item_if import mpool_pkg::*;;

    logic             valid;
    logic             ready;
    func_t            func;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [CH_W-1:0]  channel;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, func, row, col, channel, pixel_value, input ready);
    modport sink   (input valid, func, row, col, channel, pixel_value, output ready);

endinterface

### sv/mpool_result_if.sv
// ----------------------------------------------------------------------------
// mpool_result_if
// Result channel: pooled maximum and empty-window flag.
// ----------------------------------------------------------------------------
interface mpool_result_if import mpool_pkg::*;;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] max_value;
    logic             window_empty;

    modport source (output valid, max_value, window_empty, input ready);
    modport sink   (input valid, max_value, window_empty, output ready);

endinterface

### sv/mpool_cfg.sv
// ----------------------------------------------------------------------------
// mpool_cfg
// APB-style configuration registers for the pooling geometry.
// ----------------------------------------------------------------------------
module mpool_cfg import mpool_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_height <= RST_SRC_HEIGHT;
            cfg_reg.src_width  <= RST_SRC_WIDTH;
            cfg_reg.kernel_y   <= RST_KERNEL;
            cfg_reg.kernel_x   <= RST_KERNEL;
            cfg_reg.stride_y   <= RST_STRIDE;
            cfg_reg.stride_x   <= RST_STRIDE;
            cfg_reg.pad_y      <= RST_PAD;
            cfg_reg.pad_x      <= RST_PAD;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[DIM_W-1:0];
                REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[DIM_W-1:0];
                REG_KERNEL_Y:   cfg_reg.kernel_y   <= pwdata[DIM_W-1:0];
                REG_KERNEL_X:   cfg_reg.kernel_x   <= pwdata[DIM_W-1:0];
                REG_STRIDE_Y:   cfg_reg.stride_y   <= pwdata[DIM_W-1:0];
                REG_STRIDE_X:   cfg_reg.stride_x   <= pwdata[DIM_W-1:0];
                REG_PAD_Y:      cfg_reg.pad_y      <= pwdata[PAD_W-1:0];
                REG_PAD_X:      cfg_reg.pad_x      <= pwdata[PAD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SRC_HEIGHT: prdata = PDATA_W'(cfg_reg.src_height);
            REG_SRC_WIDTH:  prdata = PDATA_W'(cfg_reg.src_width);
            REG_KERNEL_Y:   prdata = PDATA_W'(cfg_reg.kernel_y);
            REG_KERNEL_X:   prdata = PDATA_W'(cfg_reg.kernel_x);
            REG_STRIDE_Y:   prdata = PDATA_W'(cfg_reg.stride_y);
            REG_STRIDE_X:   prdata = PDATA_W'(cfg_reg.stride_x);
            REG_PAD_Y:      prdata = PDATA_W'(cfg_reg.pad_y);
            REG_PAD_X:      prdata = PDATA_W'(cfg_reg.pad_x);
            default:        prdata = '0;
        endcase
    end

endmodule

### sv/mpool_ctrl.sv
// ----------------------------------------------------------------------------
// mpool_ctrl
// Sequencer that steps a query through window setup, scan and result hand-off.
// ----------------------------------------------------------------------------
module mpool_ctrl import mpool_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  func_t item_func,
    output logic  item_ready,
    input  sts_t  sts,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && (item_func == FUNC_QUERY))
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = sts.win_ok ? ST_SCAN : ST_DONE;
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.accept = item_valid;
            end
            ST_SPAN:  cmd.span = 1'b1;
            ST_CLAMP: cmd.clamp = 1'b1;
            ST_SCAN:  cmd.scan = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  cmd.out_load = sts.out_free;
            default:  ;
        endcase
    end

endmodule

### sv/mpool_dp.sv
// ----------------------------------------------------------------------------
// mpool_dp
// Tensor store, window arithmetic, scan counters and running maximum.
// ----------------------------------------------------------------------------
module mpool_dp import mpool_pkg::*;
#(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int CHANNELS   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  func_t            item_func,
    input  logic [POS_W-1:0] item_row,
    input  logic [POS_W-1:0] item_col,
    input  logic [CH_W-1:0]  item_channel,
    input  logic [PIX_W-1:0] item_pixel,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [PIX_W-1:0] result_max,
    output logic             result_empty
);

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIX_W-1:0] mem [DEPTH];

    logic [POS_W-1:0]        row_reg;
    logic [POS_W-1:0]        col_reg;
    logic [CH_W-1:0]         ch_reg;
    logic signed [SPAN_W-1:0] start_y_reg;
    logic signed [SPAN_W-1:0] start_x_reg;
    logic signed [SPAN_W-1:0] end_y_reg;
    logic signed [SPAN_W-1:0] end_x_reg;
    logic signed [SPAN_W-1:0] start_y_next;
    logic signed [SPAN_W-1:0] start_x_next;
    logic signed [SPAN_W-1:0] eff_y;
    logic signed [SPAN_W-1:0] eff_x;
    logic signed [SPAN_W-1:0] lo_y;
    logic signed [SPAN_W-1:0] lo_x;
    logic signed [SPAN_W-1:0] hi_y;
    logic signed [SPAN_W-1:0] hi_x;
    logic [DIM_W-1:0]        eff_h;
    logic [DIM_W-1:0]        eff_w;
    logic                    ch_ok;
    logic                    win_ok;
    logic [DIM_W-1:0]        cur_h_reg;
    logic [DIM_W-1:0]        cur_w_reg;
    logic [DIM_W-1:0]        w_lo_reg;
    logic [DIM_W-1:0]        h_hi_reg;
    logic [DIM_W-1:0]        w_hi_reg;
    logic [DIM_W-1:0]        cur_h_inc;
    logic [DIM_W-1:0]        cur_w_inc;
    logic                    row_end;
    logic                    empty_reg;
    logic [PIX_W-1:0]        best_reg;
    logic [PIX_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;
    logic                    out_valid_reg;
    logic [PIX_W-1:0]        out_max_reg;
    logic                    out_empty_reg;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;

    assign wr_en = cmd.accept && (item_func == FUNC_LOAD)
                   && (32'(item_row) < MAX_HEIGHT) && (32'(item_col) < MAX_WIDTH)
                   && (32'(item_channel) < CHANNELS);
    assign wr_addr = AW'((32'(item_row) * MAX_WIDTH + 32'(item_col)) * CHANNELS
                         + 32'(item_channel));
    assign rd_addr = AW'((32'(cur_h_reg) * MAX_WIDTH + 32'(cur_w_reg)) * CHANNELS
                         + 32'(ch_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item_pixel;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign start_y_next = $signed(SPAN_W'(row_reg) * SPAN_W'(cfg.stride_y))
                          - $signed(SPAN_W'(cfg.pad_y));
    assign start_x_next = $signed(SPAN_W'(col_reg) * SPAN_W'(cfg.stride_x))
                          - $signed(SPAN_W'(cfg.pad_x));

    assign eff_h = (32'(cfg.src_height) < MAX_HEIGHT) ? cfg.src_height : DIM_W'(MAX_HEIGHT);
    assign eff_w = (32'(cfg.src_width) < MAX_WIDTH) ? cfg.src_width : DIM_W'(MAX_WIDTH);
    assign eff_y = $signed(SPAN_W'(eff_h));
    assign eff_x = $signed(SPAN_W'(eff_w));
    assign hi_y  = (end_y_reg > eff_y) ? eff_y : end_y_reg;
    assign hi_x  = (end_x_reg > eff_x) ? eff_x : end_x_reg;
    assign lo_y  = (start_y_reg < 0) ? '0 : start_y_reg;
    assign lo_x  = (start_x_reg < 0) ? '0 : start_x_reg;
    assign ch_ok = 32'(ch_reg) < CHANNELS;
    assign win_ok = ch_ok && (hi_y > lo_y) && (hi_x > lo_x);

    assign cur_h_inc = cur_h_reg + 7'd1;
    assign cur_w_inc = cur_w_reg + 7'd1;
    assign row_end   = cur_w_inc == w_hi_reg;

    assign sts.win_ok    = win_ok;
    assign sts.scan_last = row_end && (cur_h_inc == h_hi_reg);
    assign sts.out_free  = !out_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= item_row;
            col_reg <= item_col;
            ch_reg  <= item_channel;
        end
        if (cmd.span)
        begin
            start_y_reg <= start_y_next;
            start_x_reg <= start_x_next;
            end_y_reg   <= start_y_next + $signed(SPAN_W'(cfg.kernel_y));
            end_x_reg   <= start_x_next + $signed(SPAN_W'(cfg.kernel_x));
        end
        if (cmd.clamp)
        begin
            cur_h_reg <= lo_y[DIM_W-1:0];
            cur_w_reg <= lo_x[DIM_W-1:0];
            w_lo_reg  <= lo_x[DIM_W-1:0];
            h_hi_reg  <= hi_y[DIM_W-1:0];
            w_hi_reg  <= hi_x[DIM_W-1:0];
            empty_reg <= !win_ok;
        end
        else if (cmd.scan)
        begin
            if (row_end)
            begin
                cur_w_reg <= w_lo_reg;
                cur_h_reg <= cur_h_inc;
            end
            else
            begin
                cur_w_reg <= cur_w_inc;
            end
        end
        if (cmd.accept)
        begin
            best_reg <= '0;
        end
        else if (rd_vld_reg && (rd_data_reg > best_reg))
        begin
            best_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            out_max_reg   <= best_reg;
            out_empty_reg <= empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result_max   = out_max_reg;
    assign result_empty = out_empty_reg;

endmodule

### sv/max_pool_u8_nhwc.sv
// ----------------------------------------------------------------------------
// max_pool_u8_nhwc
// Unsigned 8-bit 2-D max pooling over a height-width-channel tensor store.
//
//   Channel   Dir   Handshake        Payload
//   item      in    valid/ready      func, row, col, channel, pixel_value
//   result    out   valid/ready      max_value, window_empty
//   apb       in    psel/penable     paddr, pwdata, prdata (pready tied high)
//
// A load request is taken while the sequencer is idle. A query computes and
// clamps its window, then scans it through the single read port of the tensor
// store, which delivers one element per cycle; an empty window skips the scan.
// Reset clears control state and loads the register defaults; the store is not
// cleared. The result register frees the block for the next request while a
// result waits; a query finishes only once the previous result has been taken.
// ----------------------------------------------------------------------------
module max_pool_u8_nhwc import mpool_pkg::*;
#(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int CHANNELS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    mpool_item_if.sink         item,
    mpool_result_if.source     result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic item_rdy;

    assign item.ready = item_rdy;

    mpool_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpool_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .item_ready (item_rdy),
        .sts        (sts),
        .cmd        (cmd)
    );

    mpool_dp #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .CHANNELS   (CHANNELS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .item_func    (item.func),
        .item_row     (item.row),
        .item_col     (item.col),
        .item_channel (item.channel),
        .item_pixel   (item.pixel_value),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .result_max   (result.max_value),
        .result_empty (result.window_empty)
    );

    // An empty window must report a zero maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.window_empty |-> result.max_value == '0)
        else $error("empty window with nonzero maximum");

    // No request is taken while the store is being scanned.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !item_rdy)
        else $error("request accepted during scan");

    // At most one sequencer command is active per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.span, cmd.clamp, cmd.scan, cmd.out_load}))
        else $error("overlapping sequencer commands");

    // Handing off a result always presents it on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result.valid)
        else $error("result lost after hand-off");

endmodule

### dv/max_pool_u8_nhwc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_u8_nhwc_tb
// Self-checking bench for the unsigned 8-bit max pooling block. Requests load
// bytes into the tensor store or query one pooled output; a scoreboard keeps
// its own copy of the store and the registers, predicts each pooled maximum
// and compares it with the result channel. Register sets are changed over the
// APB port between phases and read back. Both channels idle at random.
// ----------------------------------------------------------------------------
module max_pool_u8_nhwc_tb import mpool_pkg::*; ();

    localparam int MAX_H        = 64;
    localparam int MAX_W        = 64;
    localparam int CHANS        = 16;
    localparam int STORE_DEPTH  = MAX_H * MAX_W * CHANS;
    localparam int DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    typedef struct packed
    {
        logic [PIX_W-1:0] max_value;
        logic             window_empty;
    } pooled_t;

    class pool_scoreboard;
        logic [PIX_W-1:0] pixels [STORE_DEPTH];
        bit               loaded [STORE_DEPTH];
        cfg_t             regs;
        pooled_t          pooled_due [$];
        int unsigned      mismatches;

        function new();
            regs.src_height = RST_SRC_HEIGHT;
            regs.src_width  = RST_SRC_WIDTH;
            regs.kernel_y   = RST_KERNEL;
            regs.kernel_x   = RST_KERNEL;
            regs.stride_y   = RST_STRIDE;
            regs.stride_x   = RST_STRIDE;
            regs.pad_y      = RST_PAD;
            regs.pad_x      = RST_PAD;
            mismatches      = 0;
        endfunction

        static function int entry_at(int r, int c, int ch);
            return (r * MAX_W + c) * CHANS + ch;
        endfunction

        static function bit axis_span(int pos, int stride, int pad, int kernel, int size,
                                      int limit, output int lo, output int hi);
            int eff;
            eff = (size < limit) ? size : limit;
            lo  = pos * stride - pad;
            hi  = lo + kernel;
            if (hi > eff)
                hi = eff;
            if (lo < 0)
                lo = 0;
            return hi > lo;
        endfunction

        function bit pool_window(int r, int c, output int r0, r1, c0, c1);
            bit ok_y;
            bit ok_x;
            ok_y = axis_span(r, regs.stride_y, regs.pad_y, regs.kernel_y, regs.src_height,
                             MAX_H, r0, r1);
            ok_x = axis_span(c, regs.stride_x, regs.pad_x, regs.kernel_x, regs.src_width,
                             MAX_W, c0, c1);
            return ok_y && ok_x;
        endfunction

        function void set_reg(reg_index_t idx, logic [PDATA_W-1:0] v);
            case (idx)
                REG_SRC_HEIGHT: regs.src_height = v[DIM_W-1:0];
                REG_SRC_WIDTH:  regs.src_width  = v[DIM_W-1:0];
                REG_KERNEL_Y:   regs.kernel_y   = v[DIM_W-1:0];
                REG_KERNEL_X:   regs.kernel_x   = v[DIM_W-1:0];
                REG_STRIDE_Y:   regs.stride_y   = v[DIM_W-1:0];
                REG_STRIDE_X:   regs.stride_x   = v[DIM_W-1:0];
                REG_PAD_Y:      regs.pad_y      = v[PAD_W-1:0];
                REG_PAD_X:      regs.pad_x      = v[PAD_W-1:0];
            endcase
        endfunction

        function logic [PDATA_W-1:0] reg_value(reg_index_t idx);
            logic [PDATA_W-1:0] v;
            v = '0;
            case (idx)
                REG_SRC_HEIGHT: v[DIM_W-1:0] = regs.src_height;
                REG_SRC_WIDTH:  v[DIM_W-1:0] = regs.src_width;
                REG_KERNEL_Y:   v[DIM_W-1:0] = regs.kernel_y;
                REG_KERNEL_X:   v[DIM_W-1:0] = regs.kernel_x;
                REG_STRIDE_Y:   v[DIM_W-1:0] = regs.stride_y;
                REG_STRIDE_X:   v[DIM_W-1:0] = regs.stride_x;
                REG_PAD_Y:      v[PAD_W-1:0] = regs.pad_y;
                REG_PAD_X:      v[PAD_W-1:0] = regs.pad_x;
            endcase
            return v;
        endfunction

        function void note_request(func_t f, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                   logic [CH_W-1:0] ch, logic [PIX_W-1:0] px);
            int      r0, r1, c0, c1;
            bit      ok;
            pooled_t due;
            if (f == FUNC_LOAD)
            begin
                pixels[entry_at(r, c, ch)] = px;
                loaded[entry_at(r, c, ch)] = 1'b1;
            end
            else
            begin
                ok = pool_window(r, c, r0, r1, c0, c1);
                due.max_value    = '0;
                due.window_empty = !ok;
                if (ok)
                begin
                    for (int y = r0; y < r1; y++)
                        for (int x = c0; x < c1; x++)
                            if (pixels[entry_at(y, x, ch)] > due.max_value)
                                due.max_value = pixels[entry_at(y, x, ch)];
                end
                pooled_due.push_back(due);
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] mv, logic we);
            pooled_t due;
            if (pooled_due.size() == 0)
            begin
                $error("unexpected result: max_value %0d window_empty %0b", mv, we);
                mismatches++;
                return;
            end
            due = pooled_due.pop_front();
            if (mv !== due.max_value)
            begin
                $error("max_value: expected %0d, got %0d", due.max_value, mv);
                mismatches++;
            end
            if (we !== due.window_empty)
            begin
                $error("window_empty: expected %0b, got %0b", due.window_empty, we);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mpool_item_if   item_bus ();
    mpool_result_if result_bus ();

    pool_scoreboard tracker;
    bit             calm;
    int unsigned    cycles = 0;
    int unsigned    sent = 0;

    max_pool_u8_nhwc #(
        .MAX_HEIGHT (MAX_H),
        .MAX_WIDTH  (MAX_W),
        .CHANNELS   (CHANS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic cfg_t make_cfg(int sh, int sw, int ky, int kx, int sy, int sx,
                                       int py, int px);
        cfg_t c;
        c.src_height = DIM_W'(sh);
        c.src_width  = DIM_W'(sw);
        c.kernel_y   = DIM_W'(ky);
        c.kernel_x   = DIM_W'(kx);
        c.stride_y   = DIM_W'(sy);
        c.stride_x   = DIM_W'(sx);
        c.pad_y      = PAD_W'(py);
        c.pad_x      = PAD_W'(px);
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        int ky;
        int kx;
        ky = $urandom_range(1, 6);
        kx = $urandom_range(1, 6);
        return make_cfg($urandom_range(1, 64), $urandom_range(1, 64), ky, kx,
                        $urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(0, ky), $urandom_range(0, kx));
    endfunction

    // Picks an output position whose window mostly lands inside the source.
    function automatic int aim_pos(int stride, int pad, int size, int limit);
        int eff;
        int top;
        eff = (size < limit) ? size : limit;
        if (stride == 0 || eff == 0)
            return $urandom_range(0, 63);
        top = (eff - 1 + pad) / stride;
        if (top > 63)
            top = 63;
        return $urandom_range(0, top);
    endfunction

    initial
    begin
        int unsigned stall;
        stall = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                tracker.check_result(result_bus.max_value, result_bus.window_empty);
            if (stall != 0)
            begin
                stall--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    task automatic send_item(func_t f, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                             logic [CH_W-1:0] ch, logic [PIX_W-1:0] px);
        int unsigned gap;
        item_bus.valid       <= 1'b1;
        item_bus.func        <= f;
        item_bus.row         <= r;
        item_bus.col         <= c;
        item_bus.channel     <= ch;
        item_bus.pixel_value <= px;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        tracker.note_request(f, r, c, ch, px);
        sent++;
        gap = idle_gap();
        if (gap != 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Loads every unwritten byte of the window first, so a query never reads
    // an undefined store entry.
    task automatic pool_query(int r, int c, int ch, int lo, int hi);
        int r0, r1, c0, c1;
        if (tracker.pool_window(r, c, r0, r1, c0, c1))
        begin
            for (int y = r0; y < r1; y++)
                for (int x = c0; x < c1; x++)
                    if (!tracker.loaded[pool_scoreboard::entry_at(y, x, ch)])
                        send_item(FUNC_LOAD, POS_W'(y), POS_W'(x), CH_W'(ch),
                                  PIX_W'($urandom_range(lo, hi)));
        end
        send_item(FUNC_QUERY, POS_W'(r), POS_W'(c), CH_W'(ch), PIX_W'($urandom));
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (tracker.pooled_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== tracker.reg_value(idx))
        begin
            $error("prdata: expected %0d, got %0d", tracker.reg_value(idx), prdata);
            tracker.mismatches++;
        end
    endtask

    task automatic configure(cfg_t c);
        settle();
        write_reg(REG_SRC_HEIGHT, PDATA_W'(c.src_height));
        write_reg(REG_SRC_WIDTH, PDATA_W'(c.src_width));
        write_reg(REG_KERNEL_Y, PDATA_W'(c.kernel_y));
        write_reg(REG_KERNEL_X, PDATA_W'(c.kernel_x));
        write_reg(REG_STRIDE_Y, PDATA_W'(c.stride_y));
        write_reg(REG_STRIDE_X, PDATA_W'(c.stride_x));
        write_reg(REG_PAD_Y, PDATA_W'(c.pad_y));
        write_reg(REG_PAD_X, PDATA_W'(c.pad_x));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_request();
        int unsigned roll;
        int          hi;
        roll = $urandom_range(0, 99);
        hi   = ($urandom_range(0, 9) < 2) ? 15 : 255;
        if ($urandom_range(0, 19) == 0)
            hi = 0;
        if (roll < 15)
            send_item(FUNC_LOAD, POS_W'($urandom), POS_W'($urandom), CH_W'($urandom),
                      PIX_W'($urandom));
        else if (roll < 25)
            pool_query($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                       0, hi);
        else
            pool_query(aim_pos(tracker.regs.stride_y, tracker.regs.pad_y,
                               tracker.regs.src_height, MAX_H),
                       aim_pos(tracker.regs.stride_x, tracker.regs.pad_x,
                               tracker.regs.src_width, MAX_W),
                       $urandom_range(0, 15), 0, hi);
    endtask

    // The count is in requests, window loads included.
    task automatic run_phase(cfg_t c, int unsigned count, bit quiet);
        int unsigned stop;
        configure(c);
        calm = quiet;
        stop = sent + count;
        while (sent < stop)
            random_request();
        calm = 1'b0;
    endtask

    task automatic run_directed();
        pool_query(0, 0, 0, 255, 255);
        pool_query(63, 63, 15, 0, 0);
        send_item(FUNC_LOAD, 63, 63, 15, 8'hFF);
        send_item(FUNC_QUERY, 63, 63, 15, 8'h00);
        // An oversize source is cut to the store, and a zero stride pins
        // every window to the top left corner.
        configure(make_cfg(127, 127, 2, 2, 0, 0, 0, 0));
        pool_query(63, 40, 0, 0, 255);
        configure(make_cfg(64, 64, 3, 3, 1, 1, 63, 63));
        pool_query(0, 0, 5, 0, 255);
        pool_query(63, 63, 5, 0, 15);
        configure(make_cfg(64, 64, 0, 3, 1, 1, 0, 0));
        pool_query(1, 1, 0, 0, 255);
        configure(make_cfg(0, 64, 3, 0, 1, 1, 0, 0));
        pool_query(1, 1, 0, 0, 255);
        configure(make_cfg(64, 0, 3, 3, 1, 1, 0, 0));
        pool_query(2, 2, 0, 0, 255);
    endtask

    initial
    begin
        tracker = new();
        calm    = 1'b0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.func        <= FUNC_LOAD;
        item_bus.row         <= '0;
        item_bus.col         <= '0;
        item_bus.channel     <= '0;
        item_bus.pixel_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(make_cfg(64, 1, 64, 1, 64, 64, 63, 0), 30, 1'b0);
        run_phase(make_cfg(1, 64, 1, 64, 64, 64, 0, 63), 30, 1'b0);
        run_phase(make_cfg(1, 1, 1, 1, 1, 1, 0, 0), 20, 1'b1);
        for (int p = 0; p < 8; p++)
            run_phase(random_cfg(), 60, (p == 2 || p == 5));

        settle();
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
